>>> sv/bbm_pkg.sv
// Package for the button-box to MIDI mapper.
// Holds command and register codes, the note and transposition tables,
// the message type and the sequencer states. No dependencies.
package bbm_pkg;

  localparam int NUM_COLUMNS = 11;

  // Input commands
  localparam logic [2:0] CMD_PRESS   = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_PULL    = 3'd2;
  localparam logic [2:0] CMD_PUSH    = 3'd3;
  localparam logic [2:0] CMD_ALL_OFF = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_SELECT    = 2'd0;
  localparam logic [1:0] CFG_REVERSE_ORDER = 2'd1;
  localparam logic [1:0] CFG_NOTE_VELOCITY = 2'd2;

  // MIDI status bases
  localparam logic [7:0] NOTE_ON_BASE  = 8'h90;
  localparam logic [7:0] NOTE_OFF_BASE = 8'h80;

  // Highest key_select row; larger codes use it
  localparam logic [2:0] KEY_MAX = 3'd4;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] note_number;
    logic [6:0] velocity;
  } msg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_OFF,
    ST_SCAN_ON,
    ST_FLUSH
  } state_t;

  // Push/pull note table, indexed by mapped column
  function automatic logic [6:0] note_tab(input logic [3:0] k, input logic pulled);
    logic [6:0] push_note;
    logic [6:0] pull_note;
    unique case (k)
      4'd0:    begin push_note = 7'd52; pull_note = 7'd57; end
      4'd1:    begin push_note = 7'd55; pull_note = 7'd59; end
      4'd2:    begin push_note = 7'd60; pull_note = 7'd62; end
      4'd3:    begin push_note = 7'd64; pull_note = 7'd65; end
      4'd4:    begin push_note = 7'd67; pull_note = 7'd69; end
      4'd5:    begin push_note = 7'd72; pull_note = 7'd71; end
      4'd6:    begin push_note = 7'd76; pull_note = 7'd74; end
      4'd7:    begin push_note = 7'd79; pull_note = 7'd77; end
      4'd8:    begin push_note = 7'd84; pull_note = 7'd81; end
      4'd9:    begin push_note = 7'd88; pull_note = 7'd83; end
      4'd10:   begin push_note = 7'd91; pull_note = 7'd86; end
      default: begin push_note = 7'd0;  pull_note = 7'd0;  end
    endcase
    return pulled ? pull_note : push_note;
  endfunction

  // Per-row transposition, one table row per key
  function automatic logic signed [3:0] transpose_tab(input logic [2:0] ks,
                                                      input logic [1:0] r);
    logic signed [3:0] t0;
    logic signed [3:0] t1;
    logic signed [3:0] t2;
    unique case (ks)
      3'd0:    begin t0 = 4'sd3; t1 = -4'sd2; t2 = -4'sd7; end
      3'd1:    begin t0 = 4'sd5; t1 =  4'sd0; t2 = -4'sd5; end
      3'd2:    begin t0 = 4'sd7; t1 =  4'sd2; t2 = -4'sd3; end
      3'd3:    begin t0 = 4'sd7; t1 =  4'sd2; t2 =  4'sd1; end
      default: begin t0 = 4'sd1; t1 =  4'sd0; t2 = -4'sd1; end
    endcase
    unique case (r)
      2'd1:    return t1;
      2'd2:    return t2;
      default: return t0;
    endcase
  endfunction

endpackage

>>> sv/bbm_note_unit.sv
// Note unit: column mapping, note table lookup and transposition add.
// Shared by single presses/releases and by the held-button scan. Uses bbm_pkg.
module bbm_note_unit import bbm_pkg::*; (
  input  logic [1:0] row,
  input  logic [3:0] column,
  input  logic       pulled,
  input  logic       reverse_order,
  input  logic [2:0] key_select,
  output logic [6:0] note_number
);

  logic [3:0]        k_raw;
  logic [3:0]        k;
  logic [2:0]        ks;
  logic [6:0]        base_note;
  logic signed [3:0] offset;
  logic [7:0]        sum;

  // Column to table index, mirrored when reversed
  always_comb begin
    unique case (row)
      2'd0:    k_raw = reverse_order ? 4'(NUM_COLUMNS - 2) - column : column;
      2'd1:    k_raw = reverse_order ? 4'(NUM_COLUMNS - 1) - column : column;
      default: k_raw = reverse_order ? 4'(NUM_COLUMNS - 1) - column : column + 4'd1;
    endcase
    k = (k_raw >= 4'(NUM_COLUMNS)) ? k_raw - 4'(NUM_COLUMNS) : k_raw;
  end

  // Table note plus row transposition, wrapped to 7 bits
  assign ks          = (key_select > KEY_MAX) ? KEY_MAX : key_select;
  assign base_note   = note_tab(k, pulled);
  assign offset      = transpose_tab(ks, row);
  assign sum         = {1'b0, base_note} + {{4{offset[3]}}, offset};
  assign note_number = sum[6:0];

endmodule

>>> sv/button_bellows_to_midi_mapper.sv
// Top level of the button-box to MIDI mapper: sequencer, held-button
// matrix, message staging and output register. Uses bbm_pkg, bbm_note_unit.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, cmd, row, column       | input
//  out     | out_valid/out_ready, status_byte,         | output
//          | note_number, velocity, last_of_run        |
//  cfg     | cfg_write, cfg_index, cfg_data            | input
//
// Press/release: each accepted item goes through decode and flush before the
// next is taken. Bellows change or release-all scans every valid button
// position (31 with three rows), one per cycle while the output does not
// stall, plus a note-on step per held button for a bellows change.
// The single note unit computes one message per cycle when not stalled.
// Each message waits in a staging register until the next one (or the scan
// end) shows whether it is the last; output stalls stall the scan.
// Reset (rst, synchronous) releases all buttons, sets push, and loads
// key_select 2, reverse_order 0, note_velocity 127.
module button_bellows_to_midi_mapper import bbm_pkg::*; #(
  parameter int NUM_ROWS = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [1:0] row,
  input  logic [3:0] column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] status_byte,
  output logic [6:0] note_number,
  output logic [6:0] velocity,
  output logic       last_of_run,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int         HeldW   = NUM_ROWS * NUM_COLUMNS;
  localparam int         IdxW    = $clog2(HeldW);
  localparam logic [1:0] LastRow = 2'(NUM_ROWS - 1);

  state_t       state;
  state_t       state_next;
  logic [2:0]   cmd_r;
  logic [1:0]   cur_row;
  logic [3:0]   cur_col;
  logic [HeldW-1:0] held;
  logic         pulled;
  logic         old_dir;
  logic [2:0]   key_select;
  logic         reverse_order;
  logic [6:0]   note_velocity;
  msg_t         pend;
  logic         pend_valid;
  msg_t         out_msg;
  logic         out_last;

  logic [3:0]   last_col;
  logic         btn_ok;
  logic [5:0]   pos;
  logic         pos_in_range;
  logic         held_bit;
  logic         at_end;
  logic         out_free;
  logic         can_push;
  logic         is_button;
  logic         is_bellows;
  logic         want_pull;

  // Sequencer outputs
  logic         cand_push;
  logic         cand_on;
  logic         note_dir;
  logic         scan_step;
  logic [6:0]   cand_note;
  msg_t         cand;

  // Current button position and its held bit
  assign last_col     = (cur_row == 2'd1) ? 4'(NUM_COLUMNS - 1) : 4'(NUM_COLUMNS - 2);
  assign btn_ok       = (cur_row <= LastRow) && (cur_col <= last_col);
  assign pos          = {4'd0, cur_row} * 6'(NUM_COLUMNS) + {2'd0, cur_col};
  assign pos_in_range = pos < 6'(HeldW);
  assign held_bit     = pos_in_range ? held[pos[IdxW-1:0]] : 1'b0;
  assign at_end       = (cur_col == last_col) && (cur_row == LastRow);

  assign is_button  = (cmd_r == CMD_PRESS) || (cmd_r == CMD_RELEASE);
  assign is_bellows = (cmd_r == CMD_PULL) || (cmd_r == CMD_PUSH);
  assign want_pull  = (cmd_r == CMD_PULL);

  // Staging and output register handshake
  assign out_free = !out_valid || out_ready;
  assign can_push = !pend_valid || out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (is_button) state_next = ST_FLUSH;
        else if (is_bellows && (want_pull != pulled)) state_next = ST_SCAN_OFF;
        else if (cmd_r == CMD_ALL_OFF) state_next = ST_SCAN_OFF;
        else state_next = ST_IDLE;
      end
      ST_SCAN_OFF: begin
        priority if (held_bit && !can_push) state_next = ST_SCAN_OFF;
        else if (held_bit && is_bellows) state_next = ST_SCAN_ON;
        else if (at_end) state_next = ST_FLUSH;
        else state_next = ST_SCAN_OFF;
      end
      ST_SCAN_ON: begin
        if (can_push) state_next = at_end ? ST_FLUSH : ST_SCAN_OFF;
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    cand_push = 1'b0;
    cand_on   = 1'b0;
    note_dir  = pulled;
    scan_step = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DECODE: begin
        cand_on   = (cmd_r == CMD_PRESS);
        cand_push = btn_ok && (((cmd_r == CMD_PRESS) && !held_bit) ||
                               ((cmd_r == CMD_RELEASE) && held_bit));
      end
      ST_SCAN_OFF: begin
        note_dir  = old_dir;
        cand_push = held_bit && can_push;
        scan_step = !held_bit || (can_push && !is_bellows);
      end
      ST_SCAN_ON: begin
        cand_on   = 1'b1;
        cand_push = can_push;
        scan_step = can_push;
      end
      default: ;
    endcase
  end

  // Shared note unit
  bbm_note_unit u_note (
    .row           (cur_row),
    .column        (cur_col),
    .pulled        (note_dir),
    .reverse_order (reverse_order),
    .key_select    (key_select),
    .note_number   (cand_note)
  );

  assign cand.status_byte = (cand_on ? NOTE_ON_BASE : NOTE_OFF_BASE) + {6'd0, cur_row};
  assign cand.note_number = cand_note;
  assign cand.velocity    = cand_on ? note_velocity : 7'd0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_select    <= 3'd2;
      reverse_order <= 1'b0;
      note_velocity <= 7'd127;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY_SELECT:    key_select    <= cfg_data[2:0];
        CFG_REVERSE_ORDER: reverse_order <= cfg_data[0];
        CFG_NOTE_VELOCITY: note_velocity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, matrix and bellows state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      held   <= '0;
      pulled <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DECODE) begin
        if (cand_push) held[pos[IdxW-1:0]] <= (cmd_r == CMD_PRESS);
        if (is_bellows) pulled <= want_pull;
        if (cmd_r == CMD_ALL_OFF) pulled <= 1'b0;
      end
      if ((state == ST_FLUSH) && (cmd_r == CMD_ALL_OFF)) held <= '0;
    end
  end

  // Item latch and scan counters
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r   <= cmd;
      cur_row <= row;
      cur_col <= column;
    end else if ((state == ST_DECODE) && !is_button) begin
      old_dir <= pulled;
      cur_row <= 2'd0;
      cur_col <= 4'd0;
    end else if (scan_step && !at_end) begin
      if (cur_col == last_col) begin
        cur_row <= cur_row + 2'd1;
        cur_col <= 4'd0;
      end else begin
        cur_col <= cur_col + 4'd1;
      end
    end
  end

  // Staging register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (cand_push) begin
      pend       <= cand;
      pend_valid <= 1'b1;
      if (pend_valid) begin
        out_msg   <= pend;
        out_last  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if ((state == ST_FLUSH) && pend_valid && out_free) begin
      out_msg    <= pend;
      out_last   <= 1'b1;
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status_byte = out_msg.status_byte;
  assign note_number = out_msg.note_number;
  assign velocity    = out_msg.velocity;
  assign last_of_run = out_last;

`ifndef ASSERT_OFF
  // A new item only starts once the staged message has gone out
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("item accepted with a message still staged");

  // Moving the staged message out never overwrites an unsent one
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cand_push && pend_valid) |-> out_free)
    else $error("output register overwritten");

  // The scan runs only for bellows changes and release-all
  a_scan_cmd: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN_OFF) || (state == ST_SCAN_ON)) |-> !is_button)
    else $error("scan entered for a button command");

  // Release-all leaves nothing held
  a_all_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FLUSH) && (cmd_r == CMD_ALL_OFF)) |=> (held == '0))
    else $error("held buttons remain after release-all");
`endif

endmodule

>>> dv/bbm_midi_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the button-box to MIDI mapper: watches the input, output and
// register ports, predicts every MIDI message and compares it field by field.
// Depends on bbm_pkg for command codes, register indexes and status bases.
module bbm_midi_checker import bbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [1:0]  row,
  input  logic [3:0]  column,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  note_number,
  input  logic [6:0]  velocity,
  input  logic        last_of_run,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          mismatches,
  output int          pending,
  output logic [32:0] held_map
);

  localparam int MAX_PRINTED = 100;

  // Note per table column, push and pull
  localparam logic [0:10][6:0] PUSH_NOTES = {7'd52, 7'd55, 7'd60, 7'd64, 7'd67, 7'd72,
                                             7'd76, 7'd79, 7'd84, 7'd88, 7'd91};
  localparam logic [0:10][6:0] PULL_NOTES = {7'd57, 7'd59, 7'd62, 7'd65, 7'd69, 7'd71,
                                             7'd74, 7'd77, 7'd81, 7'd83, 7'd86};
  // Transposition per key (outer) and row (inner), two's complement
  localparam logic [0:4][0:2][4:0] KEY_SHIFT = {
    5'sd3, -5'sd2, -5'sd7,
    5'sd5,  5'sd0, -5'sd5,
    5'sd7,  5'sd2, -5'sd3,
    5'sd7,  5'sd2,  5'sd1,
    5'sd1,  5'sd0, -5'sd1
  };

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] vel;
    logic       last;
  } midi_msg_t;

  midi_msg_t  expected_msgs[$];
  logic       pulled;
  logic [2:0] key_sel;
  logic       mirror;
  logic [6:0] on_velocity;

  function automatic bit button_ok(input int r, input int c);
    if (r > 2) return 1'b0;
    return (r == 1) ? (c < NUM_COLUMNS) : (c < NUM_COLUMNS - 1);
  endfunction

  // Table column after optional mirroring, then note plus row transposition
  function automatic logic [6:0] button_note(input int r, input int c, input bit bellows);
    int k;
    int ks;
    int v;
    if (r == 0) k = mirror ? 9 - c : c;
    else if (r == 1) k = mirror ? 10 - c : c;
    else k = mirror ? 10 - c : c + 1;
    ks = (key_sel > KEY_MAX) ? int'(KEY_MAX) : int'(key_sel);
    v = bellows ? int'(PULL_NOTES[k]) : int'(PUSH_NOTES[k]);
    v = v + $signed(KEY_SHIFT[ks][r]);
    return v[6:0];
  endfunction

  task automatic add_msg(input bit on, input int r, input logic [6:0] note);
    midi_msg_t m;
    m.status = 8'((on ? NOTE_ON_BASE : NOTE_OFF_BASE) + r);
    m.note   = note;
    m.vel    = on ? on_velocity : 7'd0;
    m.last   = 1'b0;
    expected_msgs.push_back(m);
  endtask

  // Apply one accepted item to the shadow matrix and queue its messages
  task automatic predict_item(input logic [2:0] op, input logic [1:0] r, input logic [3:0] c);
    int first;
    int idx;
    int i;
    int j;
    bit want;
    bit was_pulled;
    midi_msg_t tail;
    first = expected_msgs.size();
    idx = r * NUM_COLUMNS + c;
    case (op)
      CMD_PRESS: begin
        if (button_ok(r, c) && !held_map[idx]) begin
          held_map[idx] = 1'b1;
          add_msg(1'b1, r, button_note(r, c, pulled));
        end
      end
      CMD_RELEASE: begin
        if (button_ok(r, c) && held_map[idx]) begin
          held_map[idx] = 1'b0;
          add_msg(1'b0, r, button_note(r, c, pulled));
        end
      end
      CMD_PULL, CMD_PUSH: begin
        want = (op == CMD_PULL);
        if (want != pulled) begin
          was_pulled = pulled;
          pulled = want;
          // re-sound every held note, off in old direction then on in new
          for (i = 0; i < 3; i++)
            for (j = 0; j < NUM_COLUMNS; j++)
              if (button_ok(i, j) && held_map[i * NUM_COLUMNS + j]) begin
                add_msg(1'b0, i, button_note(i, j, was_pulled));
                add_msg(1'b1, i, button_note(i, j, want));
              end
        end
      end
      CMD_ALL_OFF: begin
        for (i = 0; i < 3; i++)
          for (j = 0; j < NUM_COLUMNS; j++)
            if (button_ok(i, j) && held_map[i * NUM_COLUMNS + j])
              add_msg(1'b0, i, button_note(i, j, pulled));
        held_map = '0;
        pulled = 1'b0;
      end
      default: ;
    endcase
    // flag the final message of this item
    if (expected_msgs.size() > first) begin
      tail = expected_msgs.pop_back();
      tail.last = 1'b1;
      expected_msgs.push_back(tail);
    end
  endtask

  // Print is capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_msg();
    midi_msg_t want;
    if (expected_msgs.size() == 0) begin
      report_mismatch($sformatf("message %02h %0d %0d with nothing expected",
                                status_byte, note_number, velocity));
    end else begin
      want = expected_msgs.pop_front();
      if (status_byte !== want.status)
        report_mismatch($sformatf("status_byte %02h, expected %02h", status_byte, want.status));
      if (note_number !== want.note)
        report_mismatch($sformatf("note_number %0d, expected %0d", note_number, want.note));
      if (velocity !== want.vel)
        report_mismatch($sformatf("velocity %0d, expected %0d", velocity, want.vel));
      if (last_of_run !== want.last)
        report_mismatch($sformatf("last_of_run %b, expected %b", last_of_run, want.last));
    end
  endtask

  // Output check, then input prediction, then register writes
  always @(posedge clk) begin
    if (rst) begin
      expected_msgs.delete();
      held_map = '0;
      pulled = 1'b0;
      key_sel = 3'd2;
      mirror = 1'b0;
      on_velocity = 7'd127;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) check_msg();
      if (in_valid && in_ready) predict_item(cmd, row, column);
      if (cfg_write) begin
        case (cfg_index)
          CFG_KEY_SELECT:    key_sel = cfg_data[2:0];
          CFG_REVERSE_ORDER: mirror = cfg_data[0];
          CFG_NOTE_VELOCITY: on_velocity = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_msgs.size();
  end

endmodule

>>> dv/button_bellows_to_midi_mapper_tb.sv
`timescale 1ns / 1ps
// Testbench top for the button-box to MIDI mapper: clock, reset, stimulus,
// receiver stalls and the verdict. Needs bbm_pkg, the RTL and bbm_midi_checker.
module button_bellows_to_midi_mapper_tb;
  import bbm_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int HOLD_OFF_CYCLES = 400;

  // Command codes the block leaves undefined
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = '0;
  logic [1:0]  row = '0;
  logic [3:0]  column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  status_byte;
  logic [6:0]  note_number;
  logic [6:0]  velocity;
  logic        last_of_run;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  int          mismatches;
  int          pending;
  logic [32:0] held_map;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        rx_hold = 1'b0;
  event        hold_off_req;

  button_bellows_to_midi_mapper dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .row(row), .column(column),
    .out_valid(out_valid), .out_ready(out_ready),
    .status_byte(status_byte), .note_number(note_number),
    .velocity(velocity), .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bbm_midi_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .row(row), .column(column),
    .out_valid(out_valid), .out_ready(out_ready),
    .status_byte(status_byte), .note_number(note_number),
    .velocity(velocity), .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending),
    .held_map(held_map)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Long receiver hold-off, counted here
  always begin
    @(hold_off_req);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Receiver: random stalls
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Offer one item, wait for acceptance, then idle at random
  task automatic offer(input logic [2:0] op, input logic [1:0] r, input logic [3:0] c);
    in_valid <= 1'b1;
    cmd <= op;
    row <= r;
    column <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Stop sending and wait until every expected message has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [6:0] key_data, input logic [6:0] rev_data,
                                input logic [6:0] vel_data);
    cfg_write <= 1'b1;
    cfg_index <= CFG_KEY_SELECT;
    cfg_data <= key_data;
    @(negedge clk);
    cfg_index <= CFG_REVERSE_ORDER;
    cfg_data <= rev_data;
    @(negedge clk);
    cfg_index <= CFG_NOTE_VELOCITY;
    cfg_data <= vel_data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly presses, releases of held buttons and bellows moves; some noise
  task automatic random_item();
    int pick;
    int idx;
    logic [1:0] r;
    logic [3:0] c;
    pick = $urandom_range(99);
    r = 2'($urandom_range(2));
    c = (r == 2'd1) ? 4'($urandom_range(10)) : 4'($urandom_range(9));
    if (pick < 40) begin
      offer(CMD_PRESS, r, c);
    end else if (pick < 62) begin
      if (held_map != '0) begin
        do idx = $urandom_range(32); while (!held_map[idx]);
        r = 2'(idx / NUM_COLUMNS);
        c = 4'(idx % NUM_COLUMNS);
      end
      offer(CMD_RELEASE, r, c);
    end else if (pick < 78) begin
      offer($urandom_range(1) ? CMD_PULL : CMD_PUSH, 2'($urandom_range(3)),
            4'($urandom_range(15)));
    end else if (pick < 83) begin
      offer(CMD_ALL_OFF, 2'($urandom_range(3)), 4'($urandom_range(15)));
    end else begin
      offer(3'($urandom_range(7)), 2'($urandom_range(3)), 4'($urandom_range(15)));
    end
  endtask

  task automatic run_phase(input logic [6:0] key_data, input logic [6:0] rev_data,
                           input logic [6:0] vel_data, input int tx_pct, input int rx_pct,
                           input int count, input bit hold_off);
    settle();
    apply_settings(key_data, rev_data, vel_data);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold_off) -> hold_off_req;
    repeat (count) random_item();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corner buttons, repeats, invalid buttons, spare codes
    offer(CMD_PRESS, 2'd0, 4'd0);
    offer(CMD_PRESS, 2'd1, 4'd10);
    offer(CMD_PRESS, 2'd2, 4'd9);
    offer(CMD_PRESS, 2'd2, 4'd0);
    offer(CMD_PRESS, 2'd0, 4'd0);
    offer(CMD_PULL, 2'd3, 4'd15);
    offer(CMD_PULL, 2'd0, 4'd0);
    offer(CMD_PUSH, 2'd1, 4'd7);
    offer(CMD_RELEASE, 2'd1, 4'd10);
    offer(CMD_RELEASE, 2'd1, 4'd10);
    offer(CMD_PRESS, 2'd3, 4'd15);
    offer(CMD_PRESS, 2'd0, 4'd10);
    offer(CMD_PRESS, 2'd2, 4'd15);
    offer(CMD_RELEASE, 2'd3, 4'd5);
    offer(CMD_SPARE_A, 2'd3, 4'd15);
    offer(CMD_SPARE_B, 2'd1, 4'd3);
    offer(CMD_SPARE_C, 2'd0, 4'd0);
    offer(CMD_ALL_OFF, 2'd2, 4'd9);
    offer(CMD_ALL_OFF, 2'd0, 4'd0);
    offer(CMD_PUSH, 2'd0, 4'd0);
    // release-all while pulled, then bellows back at push
    offer(CMD_PULL, 2'd0, 4'd0);
    offer(CMD_PRESS, 2'd1, 4'd5);
    offer(CMD_ALL_OFF, 2'd3, 4'd15);
    offer(CMD_PRESS, 2'd1, 4'd5);
    offer(CMD_RELEASE, 2'd1, 4'd5);

    // Random phases; buttons stay held across setting changes
    run_phase(7'd0, 7'd1, 7'd0, 0, 0, 40, 1'b0);
    run_phase(7'd4, 7'h7E, 7'd127, 55, 0, 45, 1'b0);
    run_phase(7'd7, 7'd1, 7'd1, 0, 55, 45, 1'b0);
    run_phase(7'h2D, 7'd0, 7'($urandom_range(127)), 9, 9, 45, 1'b0);
    run_phase(7'd1, 7'h7F, 7'd64, 0, 0, 45, 1'b1);
    run_phase(7'd3, 7'd0, 7'($urandom_range(127)), 55, 0, 40, 1'b0);
    run_phase(7'd2, 7'd1, 7'd127, 0, 55, 40, 1'b0);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bbm_pkg.sv
sv/bbm_note_unit.sv
sv/button_bellows_to_midi_mapper.sv
dv/bbm_midi_checker.sv
dv/button_bellows_to_midi_mapper_tb.sv
